FILE: hw/rtl/pdac_pkg.sv
// Package: item types, register indexes and saturation helper for the PD acceleration command block
package pdac_pkg;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] elapsed_time;
  } cmd_in_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               was_clipped;
  } cmd_out_t;

  localparam logic OP_TARGET = 1'b0;
  localparam logic OP_MEAS   = 1'b1;

  localparam logic [2:0] REG_KP_X     = 3'd0;
  localparam logic [2:0] REG_KP_Y     = 3'd1;
  localparam logic [2:0] REG_KP_Z     = 3'd2;
  localparam logic [2:0] REG_KV_X     = 3'd3;
  localparam logic [2:0] REG_KV_Y     = 3'd4;
  localparam logic [2:0] REG_KV_Z     = 3'd5;
  localparam logic [2:0] REG_MAX_ACC  = 3'd6;
  localparam logic [2:0] REG_FD_MODE  = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // saturate a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'(S32_MAX);
    lo = 66'(S32_MIN);
    if (v > hi)      sat32 = S32_MAX;
    else if (v < lo) sat32 = S32_MIN;
    else             sat32 = v[31:0];
  endfunction

endpackage

FILE: hw/rtl/position_pd_accel_command_top.sv
// Top level: three-axis PD position controller with acceleration norm limit
//
// Input channel (in_valid/in_ready/in_data) takes target items and measurement
// items. A target item loads target position and velocity and
// gives no result. A measurement item gives one result item on the output
// channel (out_valid/out_ready/out_data); the configuration channel
// (cfg_valid/cfg_ready/cfg_index/cfg_data) writes gains, the limit and the mode.
// Arithmetic uses one 32x32 multiplier, one radix-2 divider that retires one
// quotient bit a cycle and a bit-serial square root. A measurement item runs:
// velocity derivation (a divide per axis in finite-difference mode with
// nonzero time, a position copy with zero time, none with measured velocity);
// error and gain products; norm square; when clipping, square root and a
// divide per axis of rescaling; output load. The next item can be taken once
// the result is loaded. in_ready is high only while idle; a finished result
// waits in the output register, and a new item may be accepted meanwhile. A
// stalled receiver holds the next result back until the waiting one is taken.
// Reset (rst, synchronous) loads default gains, limit and mode and clears the
// control state, targets, previous positions, velocities and out_valid.
module position_pd_accel_command_top #(
  parameter int FRAC_BITS   = 16,
  parameter int GRAVITY_Q16 = 642253
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdac_pkg::cmd_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdac_pkg::cmd_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FD     = 4'd1;
  localparam logic [3:0] S_FD_DIV = 4'd2;
  localparam logic [3:0] S_ERR    = 4'd3;
  localparam logic [3:0] S_SQ     = 4'd4;
  localparam logic [3:0] S_MX     = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_SC     = 4'd7;
  localparam logic [3:0] S_SC_DIV = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [1:0] ax;
  logic [1:0] ph;
  logic [5:0] cnt;
  logic       clip;

  logic [31:0] kp [3];
  logic [31:0] kv [3];
  logic [31:0] max_acc;
  logic        fd_mode;

  logic signed [31:0] tpos [3];
  logic signed [31:0] tvel [3];
  logic signed [31:0] ppos [3];
  logic signed [31:0] cvel [3];
  logic signed [31:0] pin  [3];
  logic        [31:0] dt;

  logic signed [33:0] acc_a [3];
  logic signed [65:0] acc_t;
  logic        [63:0] sumsq;
  logic        [63:0] prod;
  logic        [31:0] norm;

  // divider: dvd shifts out dividend bits and collects quotient bits
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        q_bit;
  logic [31:0] rem_next;
  logic [63:0] dvd_next;

  logic [63:0] sq_n;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [63:0] sq_try;

  logic signed [32:0] pe_w, ve_w, fd_d;
  logic signed [31:0] pe, ve;
  logic               pe_neg, ve_neg, fd_neg, a_neg;
  logic        [31:0] pe_mag, ve_mag, a_mag;
  logic        [32:0] fd_mag;
  logic        [31:0] mul_a, mul_b;
  logic        [63:0] term_u;
  logic signed [65:0] term_s;
  logic signed [65:0] fb_sum;
  logic signed [31:0] fd_vel;
  logic signed [33:0] acc_z;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    pe_w   = 33'(pin[ax]) - 33'(tpos[ax]);
    ve_w   = 33'(cvel[ax]) - 33'(tvel[ax]);
    pe     = pdac_pkg::sat32(66'(pe_w));
    ve     = pdac_pkg::sat32(66'(ve_w));
    pe_neg = pe[31];
    ve_neg = ve[31];
    pe_mag = pe_neg ? 32'(-pe) : 32'(pe);
    ve_mag = ve_neg ? 32'(-ve) : 32'(ve);
    fd_d   = 33'(pin[ax]) - 33'(ppos[ax]);
    fd_neg = fd_d[32];
    fd_mag = fd_neg ? 33'(-fd_d) : 33'(fd_d);
    a_neg  = acc_a[ax][33];
    a_mag  = a_neg ? 32'(-acc_a[ax]) : acc_a[ax][31:0];
    acc_z  = acc_a[2] + 34'(GRAVITY_Q16);

    term_u = prod >> FRAC_BITS;
    term_s = (state == S_ERR && ph == 2'd1) ?
             (pe_neg ? -66'(term_u) : 66'(term_u)) :
             (ve_neg ? -66'(term_u) : 66'(term_u));
    fb_sum = acc_t + term_s;

    rem_sh   = {rem, dvd[63]};
    q_bit    = (rem_sh >= {1'b0, dvs});
    rem_next = q_bit ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
    dvd_next = {dvd[62:0], q_bit};

    // finite-difference velocity, quotient saturated by sign
    if (!fd_neg) fd_vel = (dvd_next[63:31] != '0) ? pdac_pkg::S32_MAX : dvd_next[31:0];
    else         fd_vel = (dvd_next[63:31] != '0) ? pdac_pkg::S32_MIN
                                                  : -dvd_next[31:0];

    sq_try = sq_res + sq_bit;

    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ERR: begin
        if (ph == 2'd0) begin
          mul_a = pe_mag; mul_b = kp[ax];
        end else begin
          mul_a = ve_mag; mul_b = kv[ax];
        end
      end
      S_SQ: begin
        mul_a = a_mag; mul_b = a_mag;
      end
      S_MX: begin
        mul_a = max_acc; mul_b = max_acc;
      end
      S_SC: begin
        mul_a = a_mag; mul_b = max_acc;
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp[0] <= 32'd655360;  kp[1] <= 32'd655360;  kp[2] <= 32'd1310720;
      kv[0] <= 32'd327680;  kv[1] <= 32'd327680;  kv[2] <= 32'd655360;
      max_acc <= 32'd589824;
      fd_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pdac_pkg::REG_KP_X:    kp[0]   <= cfg_data;
        pdac_pkg::REG_KP_Y:    kp[1]   <= cfg_data;
        pdac_pkg::REG_KP_Z:    kp[2]   <= cfg_data;
        pdac_pkg::REG_KV_X:    kv[0]   <= cfg_data;
        pdac_pkg::REG_KV_Y:    kv[1]   <= cfg_data;
        pdac_pkg::REG_KV_Z:    kv[2]   <= cfg_data;
        pdac_pkg::REG_MAX_ACC: max_acc <= cfg_data;
        pdac_pkg::REG_FD_MODE: fd_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ax        <= '0;
      ph        <= '0;
      cnt       <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        tpos[i] <= '0; tvel[i] <= '0; ppos[i] <= '0; cvel[i] <= '0;
      end
    end else begin
      // the output state reloads out_valid itself
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.operation == pdac_pkg::OP_TARGET) begin
              tpos[0] <= in_data.pos_x; tpos[1] <= in_data.pos_y;
              tpos[2] <= in_data.pos_z;
              tvel[0] <= in_data.vel_x; tvel[1] <= in_data.vel_y;
              tvel[2] <= in_data.vel_z;
            end else begin
              pin[0] <= in_data.pos_x; pin[1] <= in_data.pos_y;
              pin[2] <= in_data.pos_z;
              dt     <= in_data.elapsed_time;
              ax     <= '0;
              ph     <= '0;
              sumsq  <= '0;
              clip   <= 1'b0;
              if (fd_mode) begin
                state <= S_FD;
              end else begin
                cvel[0] <= in_data.vel_x; cvel[1] <= in_data.vel_y;
                cvel[2] <= in_data.vel_z;
                state   <= S_ERR;
              end
            end
          end
        end
        S_FD: begin
          if (dt != '0) begin
            dvd   <= 64'(fd_mag) << FRAC_BITS;
            rem   <= '0;
            dvs   <= dt;
            cnt   <= '0;
            state <= S_FD_DIV;
          end else begin
            ppos[ax] <= pin[ax];
            ax       <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
            if (ax == 2'd2) state <= S_ERR;
          end
        end
        S_FD_DIV: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            cvel[ax] <= fd_vel;
            ppos[ax] <= pin[ax];
            ax       <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
            state    <= (ax == 2'd2) ? S_ERR : S_FD;
          end
        end
        S_ERR: begin
          case (ph)
            2'd0: ph <= 2'd1;
            2'd1: begin
              acc_t <= term_s;
              ph    <= 2'd2;
            end
            default: begin
              acc_a[ax] <= 34'(pdac_pkg::sat32(-fb_sum));
              ph        <= 2'd0;
              ax        <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
              if (ax == 2'd2) state <= S_SQ;
            end
          endcase
        end
        S_SQ: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            sumsq <= sumsq + prod;
            ph    <= 2'd0;
            ax    <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
            if (ax == 2'd2) state <= S_MX;
          end
        end
        S_MX: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph <= 2'd0;
            if (sumsq > prod) begin
              clip   <= 1'b1;
              sq_n   <= sumsq;
              sq_res <= '0;
              sq_bit <= 64'd1 << 62;
              cnt    <= '0;
              state  <= S_SQRT;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SQRT: begin
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            // last step: settled root is this cycle's next value
            if (sq_n >= sq_try) norm <= sq_res[32:1] + sq_bit[31:0];
            else                norm <= (sq_res[32:1] == '0) ? 32'd1 : sq_res[32:1];
            ax    <= '0;
            ph    <= '0;
            state <= S_SC;
          end
        end
        S_SC: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            ph    <= 2'd0;
            dvd   <= prod;
            rem   <= '0;
            dvs   <= norm;
            cnt   <= '0;
            state <= S_SC_DIV;
          end
        end
        S_SC_DIV: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            acc_a[ax] <= a_neg ? -34'(dvd_next[31:0]) : 34'(dvd_next[31:0]);
            ax        <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
            state     <= (ax == 2'd2) ? S_OUT : S_SC;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.accel_x     <= pdac_pkg::sat32(66'(acc_a[0]));
            out_data.accel_y     <= pdac_pkg::sat32(66'(acc_a[1]));
            out_data.accel_z     <= pdac_pkg::sat32(66'(acc_z));
            out_data.was_clipped <= clip;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");

  a_sqrt_only_clipped: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT || state == S_SC || state == S_SC_DIV) |-> clip)
    else $error("rescale without clipping");

  a_out_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> (state == S_OUT || (state == S_IDLE && out_valid)))
    else $error("output state left without result");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_DIV) |-> (dvs != '0)) else $error("zero divisor in rescale");

endmodule
